// ===== sv/cmsc_pkg.sv =====
`default_nettype none

package cmsc_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int ROW_LIMIT      = 1024;
  localparam int ROW_BITS       = 10;
  localparam int MIN_SIZE       = 3;
  localparam int CROSS_POINTS   = 5;

  localparam int COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int SIZE_BITS   = 11;
  localparam int THRESH_BITS = 8;
  localparam int CFG_BITS    = 11;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 2'd2;

  localparam logic [SIZE_BITS-1:0]   WIDTH_RST  = 11'd8;
  localparam logic [SIZE_BITS-1:0]   HEIGHT_RST = 11'd6;
  localparam logic [THRESH_BITS-1:0] THRESH_RST = 8'd6;

endpackage

`default_nettype wire

// ===== sv/cmsc_pixel_if.sv =====
`default_nettype none

interface cmsc_pixel_if #(
  parameter int PIXEL_BITS = cmsc_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// ===== sv/cmsc_total_if.sv =====
`default_nettype none

interface cmsc_total_if;
  logic                            valid;
  logic                            ready;
  logic [cmsc_pkg::COUNT_BITS-1:0] star_total;

  modport source (output valid, output star_total, input ready);
  modport sink   (input valid, input star_total, output ready);
endinterface

`default_nettype wire

// ===== sv/cmsc_ram.sv =====
`default_nettype none

module cmsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output      logic [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the entry being written returns the old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== sv/cross_mean_star_counter.sv =====
`default_nettype none

// Channel    Dir  Payload                  Beat
// pixel_in   in   pixel_value [PIXEL_BITS] one pixel, raster order
// total_out  out  star_total  [20]         star count of a finished frame
// cfg        in   cfg_index, cfg_data      one register write per cycle
//
// One pixel per cycle, back to back, unless pixel_in stalls. The line store
// read of an accepted pixel is registered into stage 1, where the sum, threshold
// compare, count update and write-back happen; totals go to the output register.
// Both line rows share one dual-read RAM entry per column; a write-back that
// meets a read of the same column in that cycle is forwarded.
// Synchronous reset clears counters, count and output; the line store is not cleared.
// pixel_in stalls only while two frame totals wait on total_out.

module cross_mean_star_counter #(
  parameter int MAX_WIDTH  = cmsc_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = cmsc_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  cmsc_pixel_if.sink                             pixel_in,
  cmsc_total_if.source                           total_out,
  input  wire logic                              cfg_we,
  input  wire logic [cmsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [cmsc_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = cmsc_pkg::ROW_BITS;
  localparam int NB    = cmsc_pkg::COUNT_BITS;
  localparam int SW    = PIXEL_BITS + 3;
  localparam int CMPW  = (SW > 11) ? SW : 11;
  localparam int EW    = 2 * PIXEL_BITS;

  // configuration
  logic [cmsc_pkg::SIZE_BITS-1:0]   image_width;
  logic [cmsc_pkg::SIZE_BITS-1:0]   image_height;
  logic [cmsc_pkg::THRESH_BITS-1:0] mean_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= cmsc_pkg::WIDTH_RST;
      image_height   <= cmsc_pkg::HEIGHT_RST;
      mean_threshold <= cmsc_pkg::THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cmsc_pkg::REG_WIDTH:  image_width    <= cfg_data;
        cmsc_pkg::REG_HEIGHT: image_height   <= cfg_data;
        cmsc_pkg::REG_THRESH: mean_threshold <= cfg_data[cmsc_pkg::THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0]   wid32, hgt32;
  logic [CW-1:0] wlast;
  logic [RW-1:0] hlast;

  always_comb begin
    wid32 = 32'(image_width);
    hgt32 = 32'(image_height);
    if (wid32 < 32'(cmsc_pkg::MIN_SIZE)) begin
      wlast = CW'(cmsc_pkg::MIN_SIZE - 1);
    end else if (wid32 > 32'(MAX_WIDTH)) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(wid32 - 32'd1);
    end
    if (hgt32 < 32'(cmsc_pkg::MIN_SIZE)) begin
      hlast = RW'(cmsc_pkg::MIN_SIZE - 1);
    end else if (hgt32 > 32'(cmsc_pkg::ROW_LIMIT)) begin
      hlast = RW'(cmsc_pkg::ROW_LIMIT - 1);
    end else begin
      hlast = RW'(hgt32 - 32'd1);
    end
  end

  // stage 0: accept, position, line store read
  logic          in_ready;
  logic          accept;
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_cur;
  logic [CW-1:0] addr_b;
  logic          row_end;
  logic          frame_end;
  logic          test_cur;

  assign accept = pixel_in.valid && in_ready;
  assign pixel_in.ready = in_ready;

  always_comb begin
    col_cur   = (col_pos > wlast) ? wlast : col_pos;
    row_end   = (col_cur == wlast);
    frame_end = row_end && (row_pos >= hlast);
    addr_b    = row_end ? '0 : col_cur + 1'b1;
    test_cur  = (row_pos >= RW'(2)) && (col_cur != '0) && !row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos <= '0;
        row_pos <= frame_end ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_cur + 1'b1;
      end
    end
  end

  // stage 1: cross sum, compare, count, write-back
  logic                  s1_valid;
  logic [CW-1:0]         s1_col;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic                  s1_test;
  logic                  s1_last;
  logic                  s1_fwd_a;
  logic                  s1_fwd_b;
  logic [EW-1:0]         s1_fwd_entry;
  logic [PIXEL_BITS-1:0] s1_fwd_pix;
  logic [PIXEL_BITS-1:0] left_held;

  logic [EW-1:0]         rd_entry;
  logic [EW-1:0]         rd_right;
  logic [EW-1:0]         entry;
  logic [PIXEL_BITS-1:0] up_pix, centre, right_pix;
  logic [EW-1:0]         wr_entry;
  logic                  fwd_a, fwd_b;

  cmsc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk       (clk),
    .wr_en     (s1_valid),
    .wr_addr   (s1_col),
    .wr_data   (wr_entry),
    .rd_addr_a (col_cur),
    .rd_data_a (rd_entry),
    .rd_addr_b (addr_b),
    .rd_data_b (rd_right)
  );

  // entry holds {older row, newer row}
  always_comb begin
    entry     = s1_fwd_a ? s1_fwd_entry : rd_entry;
    up_pix    = entry[EW-1:PIXEL_BITS];
    centre    = entry[PIXEL_BITS-1:0];
    right_pix = s1_fwd_b ? s1_fwd_pix : rd_right[PIXEL_BITS-1:0];
    wr_entry  = {centre, s1_pix};
    fwd_a     = s1_valid && (s1_col == col_cur);
    fwd_b     = s1_valid && (s1_col == addr_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col       <= col_cur;
      s1_pix       <= pixel_in.pixel_value;
      s1_test      <= test_cur;
      s1_last      <= frame_end;
      s1_fwd_a     <= fwd_a;
      s1_fwd_b     <= fwd_b;
      s1_fwd_entry <= wr_entry;
      s1_fwd_pix   <= s1_pix;
    end
    if (s1_valid) begin
      left_held <= centre;
    end
  end

  // mean > thr  <=>  sum >= 5 * (thr + 1)
  logic [8:0]      thr_inc;
  logic [CMPW-1:0] bound;
  logic [CMPW-1:0] cross_sum;
  logic            is_star;

  always_comb begin
    thr_inc   = {1'b0, mean_threshold} + 9'd1;
    bound     = (CMPW'(thr_inc) << 2) + CMPW'(thr_inc);
    cross_sum = CMPW'(s1_pix) + CMPW'(up_pix) + CMPW'(centre)
              + CMPW'(right_pix) + CMPW'(left_held);
    is_star   = s1_test && (cross_sum >= bound);
  end

  logic [NB-1:0] running_count;
  logic [NB-1:0] count_next;
  logic          push;

  always_comb begin
    count_next = running_count;
    if (is_star && running_count != cmsc_pkg::COUNT_MAX) begin
      count_next = running_count + 1'b1;
    end
    push = s1_valid && s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
    end else if (s1_valid) begin
      running_count <= s1_last ? '0 : count_next;
    end
  end

  // output register with one skid slot
  logic          out_valid;
  logic [NB-1:0] out_total;
  logic          skid_valid;
  logic [NB-1:0] skid_total;
  logic          pop;

  assign pop                  = out_valid && total_out.ready;
  assign total_out.valid      = out_valid;
  assign total_out.star_total = out_total;
  assign in_ready             = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_total <= skid_total;
        if (push) begin
          skid_total <= count_next;
        end
      end else if (push) begin
        out_total <= count_next;
      end
    end else if (push) begin
      skid_total <= count_next;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a total while the output register is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid && out_valid && !pop))
    else $error("frame total pushed with both output slots full");

  a_total_shown: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("frame end did not raise total_out.valid");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    push |=> (running_count == '0))
    else $error("running count not cleared after frame end");

  a_fwd_one_deep: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_fwd_a) |-> $past(s1_valid))
    else $error("forward taken without a write-back in flight");

endmodule

`default_nettype wire

// ===== tb/cross_mean_star_counter_tb.sv =====
`default_nettype none

module cross_mean_star_counter_tb;
  import cmsc_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 6;
  localparam int STALL_LIMIT    = 4000;
  localparam int PRESSURE_HOLD  = 300;
  localparam int MIN_PIXELS     = 800;

  typedef enum int {ALL_DARK, ALL_BRIGHT, ANY_LEVEL, NEAR_LIMIT, SPECKLE} scene_e;

  class star_tally;
    bit [SIZE_BITS-1:0]   width_reg  = WIDTH_RST;
    bit [SIZE_BITS-1:0]   height_reg = HEIGHT_RST;
    bit [THRESH_BITS-1:0] thresh_reg = THRESH_RST;
    bit [PIXEL_BITS_DEF-1:0] older_row [MAX_WIDTH_DEF];
    bit [PIXEL_BITS_DEF-1:0] newer_row [MAX_WIDTH_DEF];
    int unsigned col;
    int unsigned row;
    int unsigned left_pix;
    bit [COUNT_BITS-1:0] stars;
    bit [COUNT_BITS-1:0] frame_totals [$];
    int mismatches;

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clamp_size(width_reg, MAX_WIDTH_DEF) * clamp_size(height_reg, ROW_LIMIT);
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      case (idx)
        REG_WIDTH: begin
          width_reg = data[SIZE_BITS-1:0];
        end
        REG_HEIGHT: begin
          height_reg = data[SIZE_BITS-1:0];
        end
        REG_THRESH: begin
          thresh_reg = data[THRESH_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_pixel(bit [PIXEL_BITS_DEF-1:0] p);
      int unsigned w, h, c, up, mid, sum;
      w = clamp_size(width_reg, MAX_WIDTH_DEF);
      h = clamp_size(height_reg, ROW_LIMIT);
      c = (col >= w) ? w - 1 : col;
      up = older_row[c];
      mid = newer_row[c];
      // cross is centred on the row above: down is the arriving pixel
      if (row >= 2 && c >= 1 && c + 1 < w) begin
        sum = p + up + mid + newer_row[c + 1] + left_pix;
        if (sum / CROSS_POINTS > thresh_reg && stars != COUNT_MAX) stars++;
      end
      left_pix = mid;
      older_row[c] = PIXEL_BITS_DEF'(mid);
      newer_row[c] = p;
      if (c + 1 >= w) begin
        col = 0;
        if (row + 1 >= h) begin
          frame_totals.push_back(stars);
          stars = 0;
          row = 0;
        end else begin
          row = row + 1;
        end
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_total(bit [COUNT_BITS-1:0] got);
      bit [COUNT_BITS-1:0] want;
      if (frame_totals.size() == 0) begin
        $error("star_total: expected none, actual %0d", got);
        mismatches++;
        return;
      end
      want = frame_totals.pop_front();
      if (got !== want) begin
        $error("star_total: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  cmsc_pixel_if #(.PIXEL_BITS(PIXEL_BITS_DEF)) pix_if ();
  cmsc_total_if tot_if ();

  cross_mean_star_counter #(
    .MAX_WIDTH  (MAX_WIDTH_DEF),
    .PIXEL_BITS (PIXEL_BITS_DEF)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_if),
    .total_out (tot_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  star_tally tally = new();
  bit steady;
  int hold_request;
  int pixels_sent;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit [PIXEL_BITS_DEF-1:0] next_pixel(scene_e scene);
    int v;
    case (scene)
      ALL_DARK:   return '0;
      ALL_BRIGHT: return '1;
      NEAR_LIMIT: begin
        // hover around the threshold so the mean lands on both sides of it
        v = int'($urandom_range(0, 3)) + int'(tally.thresh_reg) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIXEL_BITS_DEF-1:0];
      end
      SPECKLE: begin
        if ($urandom_range(0, 3) == 0) return '1;
        return PIXEL_BITS_DEF'($urandom_range(0, 15));
      end
      default: return PIXEL_BITS_DEF'($urandom_range(0, 255));
    endcase
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst && pix_if.valid && pix_if.ready) tally.note_pixel(pix_if.pixel_value);
    if (!rst && tot_if.valid && tot_if.ready) tally.check_total(tot_if.star_total);
  end

  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (tot_if.valid && tot_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("cross_mean_star_counter_tb: errors");
        $finish;
      end
    end
  end

  initial begin : total_receiver
    int stall;
    tot_if.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        tot_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      tot_if.ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_pixels(input int n, input scene_e scene);
    int gap;
    repeat (n) begin
      gap = pick_gap();
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pix_if.valid <= 1'b1;
      pix_if.pixel_value <= next_pixel(scene);
      @(posedge clk);
      while (!pix_if.ready) @(posedge clk);
      @(negedge clk);
    end
    // drop valid for one cycle before the next burst may raise it
    pix_if.valid <= 1'b0;
    @(negedge clk);
    pixels_sent += n;
  endtask

  task automatic send_frames(input int frames, input scene_e scene);
    send_pixels(frames * tally.frame_pixels(), scene);
  endtask

  // wait for every frame total, then let the pipeline drain
  task automatic settle();
    while (tally.frame_totals.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned t);
    logic [CFG_IDX_BITS-1:0] idx [$];
    logic [CFG_BITS-1:0]     val [$];
    idx = '{REG_WIDTH, REG_HEIGHT, REG_THRESH};
    // upper data bits of the threshold write must be dropped
    val = '{w[CFG_BITS-1:0], h[CFG_BITS-1:0], {3'($urandom_range(0, 7)), t[7:0]}};
    if ($urandom_range(0, 5) == 0) begin
      idx.push_back(REG_UNUSED);
      val.push_back(CFG_BITS'($urandom_range(0, 2047)));
    end
    settle();
    foreach (idx[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      tally.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned w, h, t;
    int roll;
    scene_e scene;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel_value = '0;
    steady = 1'b0;
    hold_request = 0;
    pixels_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes and threshold
    send_frames(1, NEAR_LIMIT);

    // smallest frame, threshold extremes
    configure(3, 3, 0);
    send_frames(1, ALL_DARK);
    send_frames(1, ALL_BRIGHT);
    configure(3, 3, 255);
    send_frames(1, ALL_BRIGHT);
    configure(3, 3, 254);
    send_frames(1, ALL_BRIGHT);

    // wide and tall frames, out-of-range sizes clamp
    configure(32, 3, 100);
    send_frames(1, NEAR_LIMIT);
    configure(3, 20, 40);
    send_frames(1, NEAR_LIMIT);
    configure(0, 1, 127);
    send_frames(2, ANY_LEVEL);
    configure(10, 2, 10);
    send_frames(1, SPECKLE);
    configure(2, 20, 20);
    send_frames(1, NEAR_LIMIT);
    configure(5, 4, 0);
    send_frames(1, ANY_LEVEL);

    // hold off the totals so the block backs up and stalls pixels
    configure(3, 3, $urandom_range(0, 80));
    hold_request = PRESSURE_HOLD;
    send_frames(12, SPECKLE);

    // back to back, no gaps
    configure(7, 5, $urandom_range(20, 120));
    steady = 1'b1;
    send_frames(4, NEAR_LIMIT);
    steady = 1'b0;

    while (pixels_sent < MIN_PIXELS) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(3, 24);
        h = $urandom_range(3, 8);
      end else begin
        w = $urandom_range(3, 8);
        h = $urandom_range(3, 6);
      end
      if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 2);
      if ($urandom_range(0, 19) == 0) h = $urandom_range(0, 2);
      roll = $urandom_range(0, 7);
      t = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255);
      configure(w, h, t);
      roll = $urandom_range(0, 9);
      scene = (roll == 0) ? ALL_DARK : (roll == 1) ? ALL_BRIGHT :
              (roll < 5) ? ANY_LEVEL : (roll < 9) ? NEAR_LIMIT : SPECKLE;
      steady = ($urandom_range(0, 5) == 0);
      send_frames($urandom_range(1, 3), scene);
      steady = 1'b0;
    end

    settle();
    if (tally.mismatches == 0 && tally.frame_totals.size() == 0) begin
      $display("cross_mean_star_counter_tb: clean");
    end else begin
      $display("cross_mean_star_counter_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/cmsc_pkg.sv
sv/cmsc_pixel_if.sv
sv/cmsc_total_if.sv
sv/cmsc_ram.sv
sv/cross_mean_star_counter.sv
tb/cross_mean_star_counter_tb.sv
